### rtl/prw_pkg.sv
// prw_pkg: shared constants, types and the square-root step for the prewitt edge unit
// no dependencies; used by every other file under rtl

package prw_pkg;

   localparam int MaxWidth   = 2048;
   localparam int ColW       = $clog2(MaxWidth);
   localparam int WidthW     = 12;
   localparam int RowW       = 16;
   localparam int PixW       = 8;
   localparam int GradW      = 11;
   localparam int AbsW       = GradW - 1;
   localparam int SqW        = 2 * AbsW;
   localparam int SumW       = SqW + 1;
   localparam int MagW       = 8;
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 16;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = QueuePtrW + 1;
   localparam int RootRemW   = MagW + 2;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrImageWidth     = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrImageHeight    = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrFirstOutputRow = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrEndOutputRow   = 2'd3;

   // positions in the emit mask, in delivery order
   localparam int EmitPrev    = 0;
   localparam int EmitLastCol = 1;
   localparam int EmitLastRow = 2;
   localparam int EmitN       = 3;

   localparam logic [MagW-1:0] BorderMag = 8'd1;
   localparam logic [MagW-1:0] SatMag    = 8'd255;

   typedef struct packed {
      logic [WidthW-1:0] image_width;
      logic [RowW-1:0]   image_height;
      logic [RowW-1:0]   first_output_row;
      logic [RowW-1:0]   end_output_row;
   } cfg_type;

   typedef struct packed {
      logic              inner;
      logic [EmitN-1:0]  emit;
      logic              frame_last;
      logic [RowW-1:0]   row;
      logic [ColW-1:0]   col;
      logic [ColW-1:0]   last_col;
   } tag_type;

   typedef struct packed {
      tag_type                  tag;
      logic signed [GradW-1:0]  gx;
      logic signed [GradW-1:0]  gy;
   } job_type;

   typedef struct packed {
      logic [MagW-1:0]     root;
      logic [RootRemW-1:0] rem;
   } sqrt_state_type;

   // one digit of the restoring square root: two radicand bits in, one root bit out
   function automatic sqrt_state_type sqrt_step(sqrt_state_type st, logic [1:0] pair);
      logic [RootRemW+1:0] acc;
      logic [RootRemW+1:0] trial;
      sqrt_state_type      nx;
      acc   = {st.rem, pair};
      trial = {2'b00, st.root, 2'b01};
      if (acc >= trial) begin
         nx.rem  = RootRemW'(acc - trial);
         nx.root = {st.root[MagW-2:0], 1'b1};
      end else begin
         nx.rem  = acc[RootRemW-1:0];
         nx.root = {st.root[MagW-2:0], 1'b0};
      end
      return nx;
   endfunction

endpackage

### rtl/prw_ifs.sv
// prw_ifs: valid/ready channel interfaces for pixel words and result words
// depends on prw_pkg

interface prw_pixel_if;
   logic                      valid;
   logic                      ready;
   logic [prw_pkg::PixW-1:0]  pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface prw_result_if;
   logic                      valid;
   logic                      ready;
   logic [prw_pkg::MagW-1:0]  magnitude;
   logic [prw_pkg::RowW-1:0]  out_row;
   logic [prw_pkg::ColW-1:0]  out_column;
   logic                      last_of_run;
   logic                      frame_done;
   modport source (output valid, output magnitude, output out_row, output out_column,
                   output last_of_run, output frame_done, input ready);
   modport sink (input valid, input magnitude, input out_row, input out_column,
                 input last_of_run, input frame_done, output ready);
endinterface

### rtl/prewitt_edge_magnitude_unit.sv
// prewitt_edge_magnitude_unit: top level with control registers, front, queue and back
// depends on prw_pkg, prw_ifs, prw_front, prw_queue, prw_back
//
//   channel      dir   handshake               carries
//   req_channel  in    valid/ready             pixel
//   rsp_channel  out   valid/ready             magnitude, out_row, out_column,
//                                              last_of_run, frame_done
//   csr_*        in    csr_write_enable        csr_index, csr_write_data
//
// one pixel per cycle while each pixel releases at most one word; a line end releases two,
// which the 4-entry queue absorbs, but each pixel of the last row after its first releases
// two words (three at its end), so that row runs below the full pixel rate
// pixel to first word: intake register, queue, squares, two root stages, sequencer,
// output register
// synchronous reset clears counters, window and valid bits; line buffers are not cleared
// a stalled rsp_channel backs up through the queue to req_channel.ready

module prewitt_edge_magnitude_unit (
   input  logic                           clock,
   input  logic                           reset,
   prw_pixel_if.sink                      req_channel,
   prw_result_if.source                   rsp_channel,
   input  logic                           csr_write_enable,
   input  logic [prw_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [prw_pkg::CsrDataW-1:0]   csr_write_data
);

   prw_pkg::cfg_type  cfg_ff, cfg_in;
   logic              q_push, q_ready, q_pop, q_valid;
   prw_pkg::job_type  push_job, pop_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            prw_pkg::CsrImageWidth: begin
               cfg_in.image_width = csr_write_data[prw_pkg::WidthW-1:0];
            end
            prw_pkg::CsrImageHeight: begin
               cfg_in.image_height = csr_write_data[prw_pkg::RowW-1:0];
            end
            prw_pkg::CsrFirstOutputRow: begin
               cfg_in.first_output_row = csr_write_data[prw_pkg::RowW-1:0];
            end
            prw_pkg::CsrEndOutputRow: begin
               cfg_in.end_output_row = csr_write_data[prw_pkg::RowW-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= prw_pkg::WidthW'(640);
         cfg_ff.image_height     <= prw_pkg::RowW'(480);
         cfg_ff.first_output_row <= '0;
         cfg_ff.end_output_row   <= prw_pkg::RowW'(65535);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   prw_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_channel),
      .cfg     (cfg_ff),
      .q_push  (q_push),
      .q_job   (push_job),
      .q_ready (q_ready)
   );

   prw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_job  (pop_job)
   );

   prw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (pop_job),
      .q_pop   (q_pop),
      .rsp     (rsp_channel)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_ready)
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("job popped from an empty queue");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && rsp_channel.frame_done) |-> rsp_channel.last_of_run)
      else $error("frame end flagged on a word that does not close its run");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_channel.valid)
      else $error("result word offered right after reset");

endmodule

### rtl/prw_front.sv
// prw_front: pixel intake, raster counters, line buffers, 3x3 window and gradients
// depends on prw_pkg and prw_ifs; feeds jobs to prw_queue

module prw_front (
   input  logic                 clock,
   input  logic                 reset,
   prw_pixel_if.sink            req,
   input  prw_pkg::cfg_type     cfg,
   output logic                 q_push,
   output prw_pkg::job_type     q_job,
   input  logic                 q_ready
);

   logic [prw_pkg::PixW-1:0] mid_mem [prw_pkg::MaxWidth];
   logic [prw_pkg::PixW-1:0] top_mem [prw_pkg::MaxWidth];

   logic [prw_pkg::ColW-1:0]   col_ff, col_in;
   logic [prw_pkg::RowW-1:0]   row_ff, row_in;
   logic [prw_pkg::WidthW-1:0] w_sat;
   logic [prw_pkg::RowW-1:0]   h_sat;
   logic                       restart;
   logic [prw_pkg::ColW-1:0]   c;
   logic [prw_pkg::RowW-1:0]   r;
   logic [prw_pkg::WidthW-1:0] c_inc;
   logic [prw_pkg::RowW:0]     r_inc;
   logic [prw_pkg::ColW-1:0]   wm1;
   logic [prw_pkg::RowW-1:0]   hm1;
   logic [prw_pkg::RowW-1:0]   r_up;
   logic                       band_up, band_cur, has_up;
   prw_pkg::tag_type           tag;

   logic                       accept, transfer;
   logic                       a_valid_ff, a_valid_in;
   prw_pkg::tag_type           a_tag_ff;
   logic [prw_pkg::PixW-1:0]   a_pixel_ff;
   logic [prw_pkg::PixW-1:0]   rd_top_ff, rd_mid_ff;
   logic [prw_pkg::PixW-1:0]   win_ff [6];
   logic [prw_pkg::GradW-1:0]  gx_pos, gx_neg, gy_pos, gy_neg;

   // clamp the image size
   always_comb begin
      if (cfg.image_width < prw_pkg::WidthW'(3)) begin
         w_sat = prw_pkg::WidthW'(3);
      end else if (cfg.image_width > prw_pkg::WidthW'(prw_pkg::MaxWidth)) begin
         w_sat = prw_pkg::WidthW'(prw_pkg::MaxWidth);
      end else begin
         w_sat = cfg.image_width;
      end
      if (cfg.image_height < prw_pkg::RowW'(3)) begin
         h_sat = prw_pkg::RowW'(3);
      end else begin
         h_sat = cfg.image_height;
      end
   end

   assign wm1 = prw_pkg::ColW'(w_sat - prw_pkg::WidthW'(1));
   assign hm1 = h_sat - prw_pkg::RowW'(1);

   // counters left outside the frame by a register write restart it
   assign restart = ({1'b0, col_ff} >= w_sat) || (row_ff >= h_sat);
   assign c = restart ? '0 : col_ff;
   assign r = restart ? '0 : row_ff;

   assign c_inc = {1'b0, c} + prw_pkg::WidthW'(1);
   assign r_inc = {1'b0, r} + (prw_pkg::RowW + 1)'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_inc >= w_sat) begin
            col_in = '0;
            row_in = (r_inc >= {1'b0, h_sat}) ? '0 : r_inc[prw_pkg::RowW-1:0];
         end else begin
            col_in = c_inc[prw_pkg::ColW-1:0];
            row_in = r;
         end
      end
   end

   // classify the item: which results it releases
   assign has_up   = (r != '0);
   assign r_up     = r - prw_pkg::RowW'(1);
   assign band_up  = (r_up >= cfg.first_output_row) && (r_up < cfg.end_output_row);
   assign band_cur = (r >= cfg.first_output_row) && (r < cfg.end_output_row);

   always_comb begin
      tag                            = '0;
      tag.inner                      = (r > prw_pkg::RowW'(1)) && (c > prw_pkg::ColW'(1));
      tag.emit[prw_pkg::EmitPrev]    = has_up && (c != '0) && band_up;
      tag.emit[prw_pkg::EmitLastCol] = has_up && (c == wm1) && band_up;
      tag.emit[prw_pkg::EmitLastRow] = has_up && (r == hm1) && band_cur;
      tag.frame_last                 = (r == hm1) && (c == wm1);
      tag.row                        = r;
      tag.col                        = c;
      tag.last_col                   = wm1;
   end

   // items that release nothing do not need a queue slot
   assign transfer   = a_valid_ff && (q_ready || (a_tag_ff.emit == '0));
   assign req.ready  = !a_valid_ff || transfer;
   assign accept     = req.valid && req.ready;
   assign a_valid_in = accept ? 1'b1 : (transfer ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_tag_ff   <= tag;
         a_pixel_ff <= req.pixel;
      end
   end

   // line buffers: read before write at the same column
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_mem[c] <= req.pixel;
         rd_mid_ff  <= mid_mem[c];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_top_ff <= top_mem[c];
      end
      if (transfer) begin
         top_mem[a_tag_ff.col] <= rd_mid_ff;
      end
   end

   // window columns: 0/1 top row, 2/3 middle row, 4/5 bottom row
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (transfer) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= rd_top_ff;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= rd_mid_ff;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= a_pixel_ff;
      end
   end

   assign gx_pos = prw_pkg::GradW'(win_ff[0]) + prw_pkg::GradW'(win_ff[2])
                 + prw_pkg::GradW'(win_ff[4]);
   assign gx_neg = prw_pkg::GradW'(rd_top_ff) + prw_pkg::GradW'(rd_mid_ff)
                 + prw_pkg::GradW'(a_pixel_ff);
   assign gy_pos = prw_pkg::GradW'(win_ff[0]) + prw_pkg::GradW'(win_ff[1])
                 + prw_pkg::GradW'(rd_top_ff);
   assign gy_neg = prw_pkg::GradW'(win_ff[4]) + prw_pkg::GradW'(win_ff[5])
                 + prw_pkg::GradW'(a_pixel_ff);

   assign q_push    = transfer && (a_tag_ff.emit != '0);
   assign q_job.tag = a_tag_ff;
   assign q_job.gx  = $signed(gx_pos - gx_neg);
   assign q_job.gy  = $signed(gy_pos - gy_neg);

endmodule

### rtl/prw_queue.sv
// prw_queue: short job queue between the front and back halves
// depends on prw_pkg

module prw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  prw_pkg::job_type  push_job,
   output logic              ready,
   input  logic              pop,
   output logic              valid,
   output prw_pkg::job_type  pop_job
);

   prw_pkg::job_type                 slot_ff [prw_pkg::QueueDepth];
   logic [prw_pkg::QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [prw_pkg::QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [prw_pkg::QueueCntW-1:0]    count_ff, count_in;

   assign ready   = (count_ff != prw_pkg::QueueCntW'(prw_pkg::QueueDepth));
   assign valid   = (count_ff != '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + prw_pkg::QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + prw_pkg::QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + prw_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - prw_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/prw_back.sv
// prw_back: squares, two-stage square root, and the result sequencer with output register
// depends on prw_pkg and prw_ifs; drains jobs from prw_queue

module prw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  prw_pkg::job_type  q_job,
   output logic              q_pop,
   prw_result_if.source      rsp
);

   logic                           en;
   logic [prw_pkg::AbsW-1:0]       ax, ay;

   logic                           m_valid_ff;
   prw_pkg::tag_type               m_tag_ff;
   logic [prw_pkg::SqW-1:0]        sqx_ff, sqy_ff;

   logic [prw_pkg::SumW-1:0]       sum;
   prw_pkg::sqrt_state_type        hi_st, lo_st;
   logic                           s1_valid_ff;
   prw_pkg::tag_type               s1_tag_ff;
   logic                           s1_sat_ff;
   prw_pkg::sqrt_state_type        s1_st_ff;
   logic [prw_pkg::MagW-1:0]       s1_low_ff;

   logic                           s2_valid_ff;
   prw_pkg::tag_type               s2_tag_ff;
   logic [prw_pkg::MagW-1:0]       s2_mag_ff, s2_mag_in;

   logic                           e_valid_ff;
   prw_pkg::tag_type               e_tag_ff;
   logic [prw_pkg::MagW-1:0]       e_mag_ff;
   logic [prw_pkg::EmitN-1:0]      e_pend_ff, e_pend_in;
   logic [prw_pkg::EmitN-1:0]      pick, pend_left;
   logic                           move, e_finish;

   logic                           rsp_valid_ff;
   logic [prw_pkg::MagW-1:0]       rsp_mag_ff, rsp_mag_in;
   logic [prw_pkg::RowW-1:0]       rsp_row_ff, rsp_row_in;
   logic [prw_pkg::ColW-1:0]       rsp_col_ff, rsp_col_in;
   logic                           rsp_last_ff, rsp_done_ff;
   logic                           out_free;

   // the whole pipe advances unless the sequencer still holds unsent words
   assign en    = !e_valid_ff || e_finish;
   assign q_pop = en && q_valid;

   assign ax = q_job.gx[prw_pkg::GradW-1] ? prw_pkg::AbsW'(-q_job.gx)
                                          : q_job.gx[prw_pkg::AbsW-1:0];
   assign ay = q_job.gy[prw_pkg::GradW-1] ? prw_pkg::AbsW'(-q_job.gy)
                                          : q_job.gy[prw_pkg::AbsW-1:0];

   // first four root digits from the upper radicand byte
   assign sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   always_comb begin
      hi_st = '0;
      for (int i = 0; i < 4; i++) begin
         hi_st = prw_pkg::sqrt_step(hi_st, sum[15 - 2 * i -: 2]);
      end
   end

   // last four digits from the lower byte
   always_comb begin
      lo_st = s1_st_ff;
      for (int i = 0; i < 4; i++) begin
         lo_st = prw_pkg::sqrt_step(lo_st, s1_low_ff[7 - 2 * i -: 2]);
      end
      if (!s1_tag_ff.inner) begin
         s2_mag_in = prw_pkg::BorderMag;
      end else if (s1_sat_ff) begin
         s2_mag_in = prw_pkg::SatMag;
      end else begin
         s2_mag_in = lo_st.root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff  <= q_valid;
         s1_valid_ff <= m_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_tag_ff  <= q_job.tag;
         sqx_ff    <= ax * ax;
         sqy_ff    <= ay * ay;
         s1_tag_ff <= m_tag_ff;
         s1_sat_ff <= (sum[prw_pkg::SumW-1:16] != '0);
         s1_st_ff  <= hi_st;
         s1_low_ff <= sum[7:0];
         s2_tag_ff <= s1_tag_ff;
         s2_mag_ff <= s2_mag_in;
      end
   end

   // sequencer: one word per cycle in mask order while the output register is free
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign move     = e_valid_ff && out_free;
   assign pick     = e_pend_ff & (~e_pend_ff + prw_pkg::EmitN'(1));
   assign pend_left = e_pend_ff & ~pick;
   assign e_finish = move && (pend_left == '0);

   always_comb begin
      rsp_mag_in = prw_pkg::BorderMag;
      rsp_row_in = e_tag_ff.row - prw_pkg::RowW'(1);
      rsp_col_in = e_tag_ff.last_col;
      if (pick[prw_pkg::EmitPrev]) begin
         rsp_mag_in = e_mag_ff;
         rsp_col_in = e_tag_ff.col - prw_pkg::ColW'(1);
      end else if (pick[prw_pkg::EmitLastRow]) begin
         rsp_row_in = e_tag_ff.row;
         rsp_col_in = e_tag_ff.col;
      end
   end

   always_comb begin
      e_pend_in = e_pend_ff;
      if (en) begin
         e_pend_in = s2_tag_ff.emit;
      end else if (move) begin
         e_pend_in = pend_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         e_pend_ff  <= '0;
      end else begin
         if (en) begin
            e_valid_ff <= s2_valid_ff;
         end
         e_pend_ff <= e_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_tag_ff <= s2_tag_ff;
         e_mag_ff <= s2_mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_mag_ff  <= rsp_mag_in;
         rsp_row_ff  <= rsp_row_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_last_ff <= (pend_left == '0);
         rsp_done_ff <= (pend_left == '0) && e_tag_ff.frame_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.magnitude   = rsp_mag_ff;
   assign rsp.out_row     = rsp_row_ff;
   assign rsp.out_column  = rsp_col_ff;
   assign rsp.last_of_run = rsp_last_ff;
   assign rsp.frame_done  = rsp_done_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for prewitt_edge_magnitude_unit, pixel words in, edge words out
// depends on prw_pkg, prw_ifs and the unit under test; predicts every edge word itself

module tb_top;

   localparam int QuietLimit = 2000;
   localparam int SettleCycles = 32;
   localparam int ResetGeomPixels = 12;
   localparam int RandomPixels = 100;

   typedef enum {PaceSlowSink, PaceSlowSource, PaceFree} pace_type;

   typedef struct packed {
      logic [prw_pkg::MagW-1:0] magnitude;
      logic [prw_pkg::RowW-1:0] row;
      logic [prw_pkg::ColW-1:0] column;
      logic                     last_word;
      logic                     frame_end;
   } edge_result_type;

   typedef struct {
      logic [prw_pkg::CsrDataW-1:0] width_reg;
      logic [prw_pkg::CsrDataW-1:0] height_reg;
      logic [prw_pkg::CsrDataW-1:0] first_row;
      logic [prw_pkg::CsrDataW-1:0] end_row;
      int                           pixels;
   } setup_type;

   typedef struct {
      logic [prw_pkg::PixW-1:0] pixel;
      int                       pinned_mag;
   } probe_type;

   logic clock;
   logic reset;
   logic                         csr_write_enable;
   logic [prw_pkg::CsrIdxW-1:0]  csr_index;
   logic [prw_pkg::CsrDataW-1:0] csr_write_data;

   prw_pixel_if  pixel_ch ();
   prw_result_if edge_ch ();

   prewitt_edge_magnitude_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (pixel_ch.sink),
      .rsp_channel      (edge_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor copy of the unit
   logic [prw_pkg::PixW-1:0]   line_mem [0:2*prw_pkg::MaxWidth-1];
   logic [prw_pkg::PixW-1:0]   win [0:5];
   int unsigned                col_pos;
   int unsigned                row_pos;
   logic [prw_pkg::WidthW-1:0] cfg_width;
   logic [prw_pkg::RowW-1:0]   cfg_height;
   logic [prw_pkg::RowW-1:0]   cfg_first;
   logic [prw_pkg::RowW-1:0]   cfg_end;

   edge_result_type pending_edges [$];
   int mismatch_count;
   int quiet_cycles;
   int pixel_gap_pct;
   int rsp_stall_pct;

   // two 3x3 frames: a hard vertical edge, then a single lit corner
   probe_type probe_pixels [18] = '{
      '{8'd255, -1}, '{8'd128, -1}, '{8'd0, -1},
      '{8'd255, -1}, '{8'd37, 1},   '{8'd0, -1},
      '{8'd255, -1}, '{8'd200, -1}, '{8'd0, 255},
      '{8'd10, -1},  '{8'd0, -1},   '{8'd0, -1},
      '{8'd0, -1},   '{8'd0, -1},   '{8'd0, -1},
      '{8'd0, -1},   '{8'd0, -1},   '{8'd0, 14}
   };

   // width above the line limit, raised flags in the width register, tall frame,
   // bands that drop rows
   setup_type special_runs [7] = '{
      '{16'h0FFF, 16'd3, 16'd0, 16'd1, 12},
      '{16'h1005, 16'd4, 16'd0, 16'hFFFF, 40},
      '{16'd7, 16'hFFFF, 16'd0, 16'hFFFF, 42},
      '{16'd6, 16'd3, 16'd0, 16'd1, 36},
      '{16'd3, 16'd3, 16'hFFFF, 16'd0, 18},
      '{16'd4, 16'd5, 16'd2, 16'd4, 40},
      '{16'd8, 16'd3, 16'd1, 16'hFFFF, 24}
   };

   always #4 clock = ~clock;

   function automatic logic [prw_pkg::MagW-1:0] edge_root(input int unsigned sq);
      logic [prw_pkg::MagW-1:0] acc;
      int unsigned              trial;
      acc = '0;
      if (sq >= 65536) begin
         return prw_pkg::SatMag;
      end
      for (int b = prw_pkg::MagW - 1; b >= 0; b--) begin
         acc[b] = 1'b1;
         trial = acc;
         if (trial * trial > sq) begin
            acc[b] = 1'b0;
         end
      end
      return acc;
   endfunction

   function automatic bit in_band(input int unsigned row);
      return row >= cfg_first && row < cfg_end;
   endfunction

   function automatic edge_result_type edge_word(input logic [prw_pkg::MagW-1:0] mag,
                                                 input int unsigned row,
                                                 input int unsigned col);
      edge_result_type e;
      e.magnitude = mag;
      e.row       = prw_pkg::RowW'(row);
      e.column    = prw_pkg::ColW'(col);
      e.last_word = 1'b0;
      e.frame_end = 1'b0;
      return e;
   endfunction

   // advance the predictor by one pixel, queue its edge words, return how many
   function automatic int predict_edges(input logic [prw_pkg::PixW-1:0] px);
      int unsigned              w;
      int unsigned              h;
      int unsigned              c;
      int unsigned              r;
      int                       gx;
      int                       gy;
      logic [prw_pkg::MagW-1:0] mag;
      logic [prw_pkg::PixW-1:0] up;
      logic [prw_pkg::PixW-1:0] mid;
      bit                       frame_last;
      edge_result_type          outs [$];
      w = cfg_width;
      h = cfg_height;
      if (w < 3) w = 3;
      if (w > prw_pkg::MaxWidth) w = prw_pkg::MaxWidth;
      if (h < 3) h = 3;
      // a setup change may leave the position outside the image
      if (col_pos >= w || row_pos >= h) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      up  = line_mem[prw_pkg::MaxWidth + c];
      mid = line_mem[c];
      frame_last = (r == h - 1) && (c == w - 1);
      if (r >= 1) begin
         if (c >= 1) begin
            mag = prw_pkg::BorderMag;
            if (r >= 2 && c >= 2) begin
               gx = int'(win[0]) + win[2] + win[4] - up - mid - px;
               gy = int'(win[0]) + win[1] + up - win[4] - win[5] - px;
               mag = edge_root(gx * gx + gy * gy);
            end
            if (in_band(r - 1)) outs.push_back(edge_word(mag, r - 1, c - 1));
         end
         if (c == w - 1 && in_band(r - 1)) begin
            outs.push_back(edge_word(prw_pkg::BorderMag, r - 1, w - 1));
         end
         if (r == h - 1 && in_band(r)) outs.push_back(edge_word(prw_pkg::BorderMag, r, c));
      end
      if (outs.size() > 0) begin
         outs[outs.size() - 1].last_word = 1'b1;
         outs[outs.size() - 1].frame_end = frame_last;
      end
      foreach (outs[i]) pending_edges.push_back(outs[i]);
      line_mem[prw_pkg::MaxWidth + c] = mid;
      line_mem[c] = px;
      win[0] = win[1];
      win[1] = up;
      win[2] = win[3];
      win[3] = mid;
      win[4] = win[5];
      win[5] = px;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
      return outs.size();
   endfunction

   function automatic logic [prw_pkg::PixW-1:0] any_pixel();
      int roll;
      roll = $urandom_range(7);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return prw_pkg::PixW'($urandom_range(255));
   endfunction

   task automatic set_pace(input pace_type pace);
      case (pace)
         PaceSlowSink: begin
            pixel_gap_pct = 38;
            rsp_stall_pct = 82;
         end
         PaceSlowSource: begin
            pixel_gap_pct = 82;
            rsp_stall_pct = 38;
         end
         default: begin
            pixel_gap_pct = 0;
            rsp_stall_pct = 0;
         end
      endcase
   endtask

   task automatic write_csr(input logic [prw_pkg::CsrIdxW-1:0] idx,
                            input logic [prw_pkg::CsrDataW-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         prw_pkg::CsrImageWidth:     cfg_width  = val[prw_pkg::WidthW-1:0];
         prw_pkg::CsrImageHeight:    cfg_height = val[prw_pkg::RowW-1:0];
         prw_pkg::CsrFirstOutputRow: cfg_first  = val[prw_pkg::RowW-1:0];
         prw_pkg::CsrEndOutputRow:   cfg_end    = val[prw_pkg::RowW-1:0];
         default: ;
      endcase
   endtask

   task automatic load_setup(input logic [prw_pkg::CsrDataW-1:0] w,
                             input logic [prw_pkg::CsrDataW-1:0] h,
                             input logic [prw_pkg::CsrDataW-1:0] first,
                             input logic [prw_pkg::CsrDataW-1:0] last);
      write_csr(prw_pkg::CsrImageWidth, w);
      write_csr(prw_pkg::CsrImageHeight, h);
      write_csr(prw_pkg::CsrFirstOutputRow, first);
      write_csr(prw_pkg::CsrEndOutputRow, last);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_pixel(input logic [prw_pkg::PixW-1:0] px, input int pinned_mag);
      int n;
      while ($urandom_range(99) < pixel_gap_pct) begin
         pixel_ch.valid <= 1'b0;
         @(posedge clock);
      end
      pixel_ch.valid <= 1'b1;
      pixel_ch.pixel <= px;
      @(posedge clock);
      while (!pixel_ch.ready) @(posedge clock);
      n = predict_edges(px);
      // hand-checked value replaces the first word of this pixel
      if (pinned_mag >= 0 && n > 0) begin
         pending_edges[pending_edges.size() - n].magnitude = prw_pkg::MagW'(pinned_mag);
      end
   endtask

   // wait for every expected word, then keep the pixel input idle while the pipe drains
   task automatic settle();
      pixel_ch.valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic run_pixels(input int count);
      repeat (count) push_pixel(any_pixel(), -1);
      settle();
   endtask

   task automatic note_bad(input string what, input edge_result_type want,
                           input edge_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected mag %0d row %0d col %0d last %0b done %0b", what,
                  want.magnitude, want.row, want.column, want.last_word, want.frame_end);
         $display("   got mag %0d row %0d col %0d last %0b done %0b",
                  got.magnitude, got.row, got.column, got.last_word, got.frame_end);
      end
   endtask

   always @(posedge clock) begin : edge_monitor
      edge_result_type got;
      edge_result_type want;
      got.magnitude = edge_ch.magnitude;
      got.row       = edge_ch.out_row;
      got.column    = edge_ch.out_column;
      got.last_word = edge_ch.last_of_run;
      got.frame_end = edge_ch.frame_done;
      if (!reset && edge_ch.valid && edge_ch.ready) begin
         if (pending_edges.size() == 0) begin
            note_bad("edge word with nothing pending", '0, got);
         end else begin
            want = pending_edges.pop_front();
            if (got !== want) note_bad("edge word mismatch", want, got);
         end
      end
      edge_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (reset || (pixel_ch.valid && pixel_ch.ready) || (edge_ch.valid && edge_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("prewitt_edge_magnitude_unit regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned frame_pixels;
      int unsigned reps;
      int unsigned random_count;
      logic [prw_pkg::CsrDataW-1:0] w_reg;
      logic [prw_pkg::CsrDataW-1:0] h_reg;
      logic [prw_pkg::CsrDataW-1:0] first;
      logic [prw_pkg::CsrDataW-1:0] last;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      pixel_ch.valid   = 1'b0;
      pixel_ch.pixel   = '0;
      edge_ch.ready    = 1'b0;
      mismatch_count   = 0;
      quiet_cycles     = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      cfg_width  = 12'd640;
      cfg_height = 16'd480;
      cfg_first  = 16'd0;
      cfg_end    = 16'hFFFF;
      set_pace(PaceSlowSink);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: a few pixels of the first row, then a narrow width forces a restart
      run_pixels(ResetGeomPixels);

      // widths and heights below three saturate up
      load_setup(16'd0, 16'd2, 16'd0, 16'hFFFF);
      foreach (probe_pixels[i]) push_pixel(probe_pixels[i].pixel, probe_pixels[i].pinned_mag);
      settle();

      foreach (special_runs[i]) begin
         load_setup(special_runs[i].width_reg, special_runs[i].height_reg,
                    special_runs[i].first_row, special_runs[i].end_row);
         run_pixels(special_runs[i].pixels);
      end

      // random geometry, always whole frames so a narrower or wider line starts clean
      random_count = 0;
      while (random_count < RandomPixels) begin
         if (random_count < RandomPixels / 2) set_pace(PaceSlowSource);
         else set_pace(PaceFree);
         w_reg = ($urandom_range(7) == 0) ? prw_pkg::CsrDataW'($urandom_range(13, 16))
                                          : prw_pkg::CsrDataW'($urandom_range(0, 12));
         h_reg = prw_pkg::CsrDataW'($urandom_range(0, 6));
         w_eff = (w_reg < 3) ? 3 : w_reg;
         h_eff = (h_reg < 3) ? 3 : h_reg;
         if ($urandom_range(9) < 6) begin
            first = 16'd0;
            last  = 16'hFFFF;
         end else begin
            first = prw_pkg::CsrDataW'($urandom_range(0, h_eff - 1));
            last  = prw_pkg::CsrDataW'($urandom_range(first, h_eff));
         end
         frame_pixels = w_eff * h_eff;
         reps = (random_count + 2 * frame_pixels <= RandomPixels) ? $urandom_range(1, 2) : 1;
         load_setup(w_reg, h_reg, first, last);
         run_pixels(reps * frame_pixels);
         random_count += reps * frame_pixels;
      end

      if (mismatch_count == 0) begin
         $display("prewitt_edge_magnitude_unit regression: pass");
      end else begin
         $display("prewitt_edge_magnitude_unit regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
rtl/prw_pkg.sv
rtl/prw_ifs.sv
rtl/prw_front.sv
rtl/prw_queue.sv
rtl/prw_back.sv
rtl/prewitt_edge_magnitude_unit.sv
tb/tb_top.sv
